/* rtl/rmq_pkg.sv */
package rmq_pkg;

  // field and datapath widths
  localparam int DATA_W      = 16;
  localparam int FRAC_W      = 14;
  localparam int NUM_W       = DATA_W + 1;
  localparam int RAD_W       = FRAC_W + 3;
  localparam int ROOT_W      = 16;
  localparam int SQIN_W      = 2 * ROOT_W;
  localparam int QUO_W       = FRAC_W + 1;
  localparam int DEN_W       = ROOT_W + 1;
  localparam int CFG_W       = 21;

  // pipeline depths
  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_STAGES  = QUO_W;
  localparam int PIPE_LAT    = 2 * SQRT_STAGES + 2 * DIV_STAGES + 6;

  // constants
  localparam logic [CFG_W-1:0]  CFG_RESET = 21'd2684;
  localparam logic [QUO_W-1:0]  COMP_MAX  = '1;
  localparam logic [DATA_W-1:0] UNIT_Q    = 16'd16384;

  // branch codes, also the index of the branch's own component
  localparam logic [1:0] BR_X = 2'd0;
  localparam logic [1:0] BR_Y = 2'd1;
  localparam logic [1:0] BR_Z = 2'd2;
  localparam logic [1:0] BR_W = 2'd3;

  typedef struct packed {
    logic [1:0]            big;
    logic [2:0][NUM_W-1:0] n;
  } sb1_t;

  typedef struct packed {
    logic [1:0]       big;
    logic [2:0]       neg;
    logic [2:0]       sat;
    logic             zero;
    logic [QUO_W-1:0] own;
  } sb2_t;

  typedef struct packed {
    logic                  ident;
    logic [3:0][QUO_W-1:0] qm;
    logic [3:0]            qs;
  } sb3_t;

  typedef struct packed {
    logic       ident;
    logic [3:0] qs;
  } sb4_t;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic [DATA_W-1:0] w;
  } res_t;

endpackage

/* rtl/rmq_sqrt.sv */
module rmq_sqrt
  import rmq_pkg::*;
(
  input  logic              clk,
  input  logic              ce,
  input  logic [SQIN_W-1:0] rad,
  output logic [ROOT_W-1:0] root
);

  logic [ROOT_W+1:0]  rem_r   [SQRT_STAGES];
  logic [ROOT_W-1:0]  root_r  [SQRT_STAGES];
  logic [SQIN_W-1:0]  rest_r  [SQRT_STAGES];
  logic [ROOT_W+1:0]  rem_nxt [SQRT_STAGES];
  logic [ROOT_W-1:0]  root_nxt[SQRT_STAGES];
  logic [SQIN_W-1:0]  rest_nxt[SQRT_STAGES];

  // one root bit per stage, two radicand bits brought down
  always_comb begin
    logic [ROOT_W+1:0] rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SQIN_W-1:0] rest_in;
    logic [ROOT_W+3:0] sh;
    logic [ROOT_W+3:0] trial;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        rest_in = rad;
      end else begin
        rem_in  = rem_r[k-1];
        root_in = root_r[k-1];
        rest_in = rest_r[k-1];
      end
      sh    = {rem_in, rest_in[SQIN_W-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
      if (sh >= trial) begin
        rem_nxt[k]  = (ROOT_W+2)'(sh - trial);
        root_nxt[k] = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = (ROOT_W+2)'(sh);
        root_nxt[k] = {root_in[ROOT_W-2:0], 1'b0};
      end
      rest_nxt[k] = {rest_in[SQIN_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rest_r[k] <= rest_nxt[k];
      end
    end
  end

  assign root = root_r[SQRT_STAGES-1];

endmodule

/* rtl/rmq_div.sv */
module rmq_div
  import rmq_pkg::*;
(
  input  logic              clk,
  input  logic              ce,
  input  logic [SQIN_W-1:0] num,
  input  logic [DEN_W-1:0]  den,
  output logic [QUO_W-1:0]  quo
);

  // restoring division, one quotient bit per stage; needs num < den << QUO_W
  logic [DEN_W-1:0] rem_r   [DIV_STAGES];
  logic [QUO_W-1:0] rest_r  [DIV_STAGES];
  logic [QUO_W-1:0] quo_r   [DIV_STAGES];
  logic [DEN_W-1:0] den_r   [DIV_STAGES];
  logic [DEN_W-1:0] rem_nxt [DIV_STAGES];
  logic [QUO_W-1:0] rest_nxt[DIV_STAGES];
  logic [QUO_W-1:0] quo_nxt [DIV_STAGES];
  logic [DEN_W-1:0] den_nxt [DIV_STAGES];

  always_comb begin
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] rest_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   sh;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        rem_in  = num[SQIN_W-1:QUO_W];
        rest_in = num[QUO_W-1:0];
        quo_in  = '0;
        den_in  = den;
      end else begin
        rem_in  = rem_r[k-1];
        rest_in = rest_r[k-1];
        quo_in  = quo_r[k-1];
        den_in  = den_r[k-1];
      end
      sh = {rem_in, rest_in[QUO_W-1]};
      if (sh >= {1'b0, den_in}) begin
        rem_nxt[k] = DEN_W'(sh - {1'b0, den_in});
        quo_nxt[k] = {quo_in[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = DEN_W'(sh);
        quo_nxt[k] = {quo_in[QUO_W-2:0], 1'b0};
      end
      rest_nxt[k] = {rest_in[QUO_W-2:0], 1'b0};
      den_nxt[k]  = den_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem_r[k]  <= rem_nxt[k];
        rest_r[k] <= rest_nxt[k];
        quo_r[k]  <= quo_nxt[k];
        den_r[k]  <= den_nxt[k];
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

/* rtl/rotation_matrix_to_quaternion.sv */
// Rotation matrix to unit quaternion, fully pipelined.
// Input channel: in_valid/in_ready carry the nine Q2.14 matrix entries of one
// request; output channel: out_valid/out_ready carry the normalized quaternion
// (x, y, z, w) in Q2.14. Both channels accept on valid and ready high.
// A request enters every cycle while in_ready is high. Its result reaches the
// output through the datapath: two 16-stage square root units
// and two banks of 15-stage dividers, plus six single-register stages.
// Throughput is one request per cycle while the receiver takes results.
// cfg_wr_en writes cfg_wr_data into the squared-length threshold (Q4.28) at
// once; write it only when no request is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and the output queue and
// sets the threshold back to its default.
// A two-entry output queue sits after the pipeline; when the receiver stalls
// the queue fills and then the whole pipeline holds, and in_ready drops.
// No request is lost or repeated under any stall pattern.
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_entry_0_0,
  input  logic [DATA_W-1:0] in_entry_0_1,
  input  logic [DATA_W-1:0] in_entry_0_2,
  input  logic [DATA_W-1:0] in_entry_1_0,
  input  logic [DATA_W-1:0] in_entry_1_1,
  input  logic [DATA_W-1:0] in_entry_1_2,
  input  logic [DATA_W-1:0] in_entry_2_0,
  input  logic [DATA_W-1:0] in_entry_2_1,
  input  logic [DATA_W-1:0] in_entry_2_2,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_quat_x,
  output logic [DATA_W-1:0] out_quat_y,
  output logic [DATA_W-1:0] out_quat_z,
  output logic [DATA_W-1:0] out_quat_w,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data
);

  logic ce;
  logic push;
  logic pop;

  // threshold register
  logic [CFG_W-1:0] minlen_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minlen_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      minlen_r <= cfg_wr_data;
    end
  end

  // valid bits travel alongside the data
  logic vld_r [PIPE_LAT];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_LAT; k++) vld_r[k] <= 1'b0;
    end else if (ce) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < PIPE_LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // stage a: branch choice, radicand and numerators
  logic signed [DATA_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [DATA_W+1:0] tr;
  logic signed [DATA_W+3:0] rad;
  logic [RAD_W-1:0]         ra_nxt, ra_r;
  sb1_t                     sa_nxt, sa_r;

  assign e00 = $signed(in_entry_0_0);
  assign e01 = $signed(in_entry_0_1);
  assign e02 = $signed(in_entry_0_2);
  assign e10 = $signed(in_entry_1_0);
  assign e11 = $signed(in_entry_1_1);
  assign e12 = $signed(in_entry_1_2);
  assign e20 = $signed(in_entry_2_0);
  assign e21 = $signed(in_entry_2_1);
  assign e22 = $signed(in_entry_2_2);

  always_comb begin
    logic signed [DATA_W+3:0] one_w;
    one_w = (DATA_W+4)'($signed({1'b0, UNIT_Q}));
    tr    = (DATA_W+2)'(e00) + (DATA_W+2)'(e11) + (DATA_W+2)'(e22);
    if (tr > 0) begin
      sa_nxt.big  = BR_W;
      rad         = one_w + (DATA_W+4)'(tr);
      sa_nxt.n[0] = NUM_W'(NUM_W'(e21) - NUM_W'(e12));
      sa_nxt.n[1] = NUM_W'(NUM_W'(e02) - NUM_W'(e20));
      sa_nxt.n[2] = NUM_W'(NUM_W'(e10) - NUM_W'(e01));
    end else if (e00 > e11 && e00 > e22) begin
      sa_nxt.big  = BR_X;
      rad         = one_w + (DATA_W+4)'(e00) - (DATA_W+4)'(e11) - (DATA_W+4)'(e22);
      sa_nxt.n[0] = NUM_W'(NUM_W'(e21) - NUM_W'(e12));
      sa_nxt.n[1] = NUM_W'(NUM_W'(e01) + NUM_W'(e10));
      sa_nxt.n[2] = NUM_W'(NUM_W'(e02) + NUM_W'(e20));
    end else if (e11 > e22) begin
      sa_nxt.big  = BR_Y;
      rad         = one_w + (DATA_W+4)'(e11) - (DATA_W+4)'(e00) - (DATA_W+4)'(e22);
      sa_nxt.n[0] = NUM_W'(NUM_W'(e02) - NUM_W'(e20));
      sa_nxt.n[1] = NUM_W'(NUM_W'(e01) + NUM_W'(e10));
      sa_nxt.n[2] = NUM_W'(NUM_W'(e12) + NUM_W'(e21));
    end else begin
      sa_nxt.big  = BR_Z;
      rad         = one_w + (DATA_W+4)'(e22) - (DATA_W+4)'(e00) - (DATA_W+4)'(e11);
      sa_nxt.n[0] = NUM_W'(NUM_W'(e10) - NUM_W'(e01));
      sa_nxt.n[1] = NUM_W'(NUM_W'(e02) + NUM_W'(e20));
      sa_nxt.n[2] = NUM_W'(NUM_W'(e21) + NUM_W'(e12));
    end
    // clamp radicand
    if (rad < 0) begin
      ra_nxt = '0;
    end else if (rad > (DATA_W+4)'($signed({1'b0, {RAD_W{1'b1}}}))) begin
      ra_nxt = '1;
    end else begin
      ra_nxt = rad[RAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ra_r <= ra_nxt;
      sa_r <= sa_nxt;
    end
  end

  // first square root
  logic [ROOT_W-1:0] root1;
  sb1_t              sb1_r [SQRT_STAGES];

  rmq_sqrt u_sqrt1 (
    .clk  (clk),
    .ce   (ce),
    .rad  ({1'b0, ra_r, {FRAC_W{1'b0}}}),
    .root (root1)
  );

  always_ff @(posedge clk) begin
    if (ce) begin
      sb1_r[0] <= sa_r;
      for (int k = 1; k < SQRT_STAGES; k++) sb1_r[k] <= sb1_r[k-1];
    end
  end

  // stage b: dividend setup, saturation and zero-divisor flags
  logic [SQIN_W-1:0] nb_nxt [3];
  logic [SQIN_W-1:0] nb_r   [3];
  logic [DEN_W-1:0]  db_r;
  sb2_t              sbb_nxt, sbb_r;

  always_comb begin
    sb1_t              s1;
    logic [DEN_W-1:0]  d;
    logic [NUM_W-1:0]  mag;
    logic              neg;
    logic [ROOT_W:0]   rp1;
    s1  = sb1_r[SQRT_STAGES-1];
    d   = {root1, 1'b0};
    rp1 = {1'b0, root1} + 1'b1;
    sbb_nxt.big  = s1.big;
    sbb_nxt.zero = (root1 == '0);
    sbb_nxt.own  = rp1[QUO_W:1];
    for (int j = 0; j < 3; j++) begin
      neg = s1.n[j][NUM_W-1];
      mag = neg ? NUM_W'(-s1.n[j]) : s1.n[j];
      nb_nxt[j] = {1'b0, mag, {FRAC_W{1'b0}}} + {{(SQIN_W-ROOT_W){1'b0}}, root1};
      sbb_nxt.neg[j] = neg;
      sbb_nxt.sat[j] = nb_nxt[j] >= {d, {QUO_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int j = 0; j < 3; j++) nb_r[j] <= nb_nxt[j];
      db_r  <= {root1, 1'b0};
      sbb_r <= sbb_nxt;
    end
  end

  // first divider bank
  logic [QUO_W-1:0] quo1 [3];
  sb2_t             sb2_r [DIV_STAGES];

  for (genvar j = 0; j < 3; j++) begin : g_div1
    rmq_div u_div (
      .clk (clk),
      .ce  (ce),
      .num (nb_r[j]),
      .den (db_r),
      .quo (quo1[j])
    );
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sb2_r[0] <= sbb_r;
      for (int k = 1; k < DIV_STAGES; k++) sb2_r[k] <= sb2_r[k-1];
    end
  end

  // stage c: assemble unnormalized quaternion
  logic [3:0][QUO_W-1:0] qm_nxt, qm_c_r;
  logic [3:0]            qs_nxt, qs_c_r;

  always_comb begin
    sb2_t                  s2;
    logic [2:0][QUO_W-1:0] cm;
    logic [2:0]            cs;
    s2 = sb2_r[DIV_STAGES-1];
    for (int j = 0; j < 3; j++) begin
      cm[j] = s2.zero ? '0 : (s2.sat[j] ? COMP_MAX : quo1[j]);
      cs[j] = s2.neg[j] & ~s2.zero;
    end
    qm_nxt = '0;
    qs_nxt = '0;
    case (s2.big)
      BR_W: begin
        qm_nxt = {s2.own, cm[2], cm[1], cm[0]};
        qs_nxt = {1'b0, cs[2], cs[1], cs[0]};
      end
      BR_X: begin
        qm_nxt = {cm[0], cm[2], cm[1], s2.own};
        qs_nxt = {cs[0], cs[2], cs[1], 1'b0};
      end
      BR_Y: begin
        qm_nxt = {cm[0], cm[2], s2.own, cm[1]};
        qs_nxt = {cs[0], cs[2], 1'b0, cs[1]};
      end
      default: begin
        qm_nxt = {cm[0], s2.own, cm[2], cm[1]};
        qs_nxt = {cs[0], 1'b0, cs[2], cs[1]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      qm_c_r <= qm_nxt;
      qs_c_r <= qs_nxt;
    end
  end

  // squares
  logic [3:0][2*QUO_W-1:0] sq_r;
  logic [3:0][QUO_W-1:0]   qm_s_r;
  logic [3:0]              qs_s_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 4; i++) sq_r[i] <= qm_c_r[i] * qm_c_r[i];
      qm_s_r <= qm_c_r;
      qs_s_r <= qs_c_r;
    end
  end

  // stage d: squared length
  logic [SQIN_W-1:0]     l2_r;
  logic [3:0][QUO_W-1:0] qm_d_r;
  logic [3:0]            qs_d_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      l2_r   <= SQIN_W'(sq_r[0]) + SQIN_W'(sq_r[1]) + SQIN_W'(sq_r[2]) + SQIN_W'(sq_r[3]);
      qm_d_r <= qm_s_r;
      qs_d_r <= qs_s_r;
    end
  end

  // second square root, short-length check rides along
  logic [ROOT_W-1:0] len;
  sb3_t              sb3_r [SQRT_STAGES];

  rmq_sqrt u_sqrt2 (
    .clk  (clk),
    .ce   (ce),
    .rad  (l2_r),
    .root (len)
  );

  always_ff @(posedge clk) begin
    if (ce) begin
      sb3_r[0].ident <= (l2_r <= {{(SQIN_W-CFG_W){1'b0}}, minlen_r});
      sb3_r[0].qm    <= qm_d_r;
      sb3_r[0].qs    <= qs_d_r;
      for (int k = 1; k < SQRT_STAGES; k++) sb3_r[k] <= sb3_r[k-1];
    end
  end

  // stage f: normalization dividends
  logic [SQIN_W-1:0] nf_r [4];
  logic [DEN_W-1:0]  df_r;
  sb4_t              sf_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 4; i++) begin
        nf_r[i] <= {{(SQIN_W-QUO_W-FRAC_W){1'b0}}, sb3_r[SQRT_STAGES-1].qm[i],
                    {FRAC_W{1'b0}}} + {{(SQIN_W-ROOT_W+1){1'b0}}, len[ROOT_W-1:1]};
      end
      df_r       <= {1'b0, len};
      sf_r.ident <= sb3_r[SQRT_STAGES-1].ident;
      sf_r.qs    <= sb3_r[SQRT_STAGES-1].qs;
    end
  end

  // second divider bank
  logic [QUO_W-1:0] quo2 [4];
  sb4_t             sb4_r [DIV_STAGES];

  for (genvar i = 0; i < 4; i++) begin : g_div2
    rmq_div u_div (
      .clk (clk),
      .ce  (ce),
      .num (nf_r[i]),
      .den (df_r),
      .quo (quo2[i])
    );
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sb4_r[0] <= sf_r;
      for (int k = 1; k < DIV_STAGES; k++) sb4_r[k] <= sb4_r[k-1];
    end
  end

  // result: signs applied, identity for a short quaternion
  res_t res;
  always_comb begin
    sb4_t                   s4;
    logic [3:0][DATA_W-1:0] v;
    s4 = sb4_r[DIV_STAGES-1];
    for (int i = 0; i < 4; i++) begin
      if (s4.ident) begin
        v[i] = (i == 3) ? UNIT_Q : '0;
      end else if (s4.qs[i]) begin
        v[i] = DATA_W'(-{1'b0, quo2[i]});
      end else begin
        v[i] = {1'b0, quo2[i]};
      end
    end
    res.x = v[0];
    res.y = v[1];
    res.z = v[2];
    res.w = v[3];
  end

  // two-entry output queue
  logic [1:0] cnt_r, cnt_nxt;
  res_t       head_r, tail_r;

  assign ce        = (cnt_r != 2'd2);
  assign in_ready  = ce;
  assign out_valid = (cnt_r != 2'd0);
  assign push      = ce & vld_r[PIPE_LAT-1];
  assign pop       = out_valid & out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cnt_r == 2'd2) begin
      head_r <= tail_r;
    end
    if (push) begin
      if (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop)) begin
        head_r <= res;
      end else begin
        tail_r <= res;
      end
    end
  end

  assign out_quat_x = head_r.x;
  assign out_quat_y = head_r.y;
  assign out_quat_z = head_r.z;
  assign out_quat_w = head_r.w;

endmodule
